@@ hdl/iofrb_pkg.sv @@
// Shared constants and types for the in-order frame reorder buffer.
`timescale 1ns / 1ps

package iofrb_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 16;
    localparam int unsigned SEQ_W            = 32;
    localparam int unsigned SCORE_W          = 31;
    localparam int unsigned HANDLE_W         = 16;

    localparam logic STATUS_EMIT   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN
    } state_t;

endpackage

@@ hdl/in_order_frame_reorder_buffer.sv @@
// Top level of the in-order frame reorder buffer: window control and result register.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Each item is first
// captured, then checked in a window against the expected sequence number;
// an in-order arrival is then followed by a drain of the parked items, and
// busy stays high until the check and any drain are done. The drain is set
// by the one read port of the slot memory, which delivers one parked item
// per cycle. Results come out of a register in the cycle after they are
// formed, each for one cycle with result_valid high; the receiver cannot
// stall, and a new item may be started while the last result is still on
// the ports. An item that lands in the window is parked and gives no result;
// a stale, out-of-window or duplicate item gives one reject result with
// status 1. After reset the block is ready at once: the slot valid bits are
// flops.

module in_order_frame_reorder_buffer #(
    parameter int unsigned WINDOW_DEPTH = iofrb_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [iofrb_pkg::SEQ_W-1:0]     seq_num,
    input  logic [iofrb_pkg::SCORE_W-1:0]   score,
    input  logic [iofrb_pkg::HANDLE_W-1:0]  payload_handle,
    output logic                            result_valid,
    output logic [iofrb_pkg::SEQ_W-1:0]     out_seq_num,
    output logic [iofrb_pkg::SCORE_W-1:0]   out_score,
    output logic [iofrb_pkg::HANDLE_W-1:0]  out_handle,
    output logic                            status,
    output logic                            last_of_run
);

    localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned DATA_W = iofrb_pkg::SCORE_W + iofrb_pkg::HANDLE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [SLOT_W:0] DEPTH_WIDE = (SLOT_W + 1)'(WINDOW_DEPTH);
    localparam logic [iofrb_pkg::SEQ_W-1:0] DEPTH_SEQ = iofrb_pkg::SEQ_W'(WINDOW_DEPTH);

    iofrb_pkg::state_t state_reg, state_next;

    logic [iofrb_pkg::SEQ_W-1:0]    ne_reg, ne_next;
    logic [SLOT_W-1:0]              ne_slot_reg, ne_slot_next;
    logic [WINDOW_DEPTH-1:0]        slot_valid_reg, slot_valid_next;
    logic [SLOT_W-1:0]              cnt_reg, cnt_next;

    logic [iofrb_pkg::SEQ_W-1:0]    seq_reg;
    logic [iofrb_pkg::SCORE_W-1:0]  score_reg;
    logic [iofrb_pkg::HANDLE_W-1:0] handle_reg;

    logic                           result_valid_reg, result_valid_next;
    logic [iofrb_pkg::SEQ_W-1:0]    out_seq_reg, out_seq_next;
    logic [iofrb_pkg::SCORE_W-1:0]  out_score_reg, out_score_next;
    logic [iofrb_pkg::HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic                           status_reg, status_next;
    logic                           last_reg, last_next;

    logic                           accept;
    logic [iofrb_pkg::SEQ_W-1:0]    win_off;
    logic                           in_window;
    logic                           wrapped;
    logic [SLOT_W:0]                slot_sum;
    logic [SLOT_W-1:0]              park_slot;
    logic [SLOT_W-1:0]              nxt_slot;
    logic                           drain_more;

    logic                           mem_we;
    logic [DATA_W-1:0]              mem_wdata;
    logic [DATA_W-1:0]              mem_rdata;

    assign busy   = (state_reg != iofrb_pkg::ST_IDLE);
    assign accept = start && !busy;

    // slot of next_expected + 1; next_expected wraps to zero, slot too
    always_comb
    begin
        if (ne_reg == '1)
        begin
            nxt_slot = '0;
        end
        else if (ne_slot_reg == LAST_SLOT)
        begin
            nxt_slot = '0;
        end
        else
        begin
            nxt_slot = ne_slot_reg + 1'b1;
        end
    end

    // park slot = seq mod depth, derived from the tracked slot of next_expected
    assign win_off   = seq_reg - ne_reg;
    assign in_window = (win_off != '0) && (win_off <= DEPTH_SEQ);
    assign wrapped   = (seq_reg < ne_reg);
    assign slot_sum  = {1'b0, ne_slot_reg} + win_off[SLOT_W:0];

    always_comb
    begin
        if (wrapped)
        begin
            park_slot = seq_reg[SLOT_W-1:0];
        end
        else if (slot_sum >= DEPTH_WIDE)
        begin
            park_slot = SLOT_W'(slot_sum - DEPTH_WIDE);
        end
        else
        begin
            park_slot = slot_sum[SLOT_W-1:0];
        end
    end

    assign drain_more = slot_valid_reg[nxt_slot] && (nxt_slot != ne_slot_reg)
                        && (cnt_reg != LAST_SLOT);
    assign mem_wdata  = {score_reg, handle_reg};

    always_comb
    begin
        state_next        = state_reg;
        ne_next           = ne_reg;
        ne_slot_next      = ne_slot_reg;
        slot_valid_next   = slot_valid_reg;
        cnt_next          = cnt_reg;
        result_valid_next = 1'b0;
        out_seq_next      = out_seq_reg;
        out_score_next    = out_score_reg;
        out_handle_next   = out_handle_reg;
        status_next       = status_reg;
        last_next         = last_reg;
        mem_we            = 1'b0;

        case (state_reg)
            iofrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = iofrb_pkg::ST_CALC;
                end
            end

            iofrb_pkg::ST_CALC:
            begin
                if (win_off == '0)
                begin
                    result_valid_next = 1'b1;
                    out_seq_next      = seq_reg;
                    out_score_next    = score_reg;
                    out_handle_next   = handle_reg;
                    status_next       = iofrb_pkg::STATUS_EMIT;
                    last_next         = !slot_valid_reg[nxt_slot];
                    ne_next           = ne_reg + 1'b1;
                    ne_slot_next      = nxt_slot;
                    cnt_next          = '0;
                    state_next        = slot_valid_reg[nxt_slot] ? iofrb_pkg::ST_DRAIN
                                                                 : iofrb_pkg::ST_IDLE;
                end
                else if (in_window && !slot_valid_reg[park_slot])
                begin
                    mem_we                     = 1'b1;
                    slot_valid_next[park_slot] = 1'b1;
                    state_next                 = iofrb_pkg::ST_IDLE;
                end
                else
                begin
                    result_valid_next = 1'b1;
                    out_seq_next      = seq_reg;
                    out_score_next    = '0;
                    out_handle_next   = '0;
                    status_next       = iofrb_pkg::STATUS_REJECT;
                    last_next         = 1'b1;
                    state_next        = iofrb_pkg::ST_IDLE;
                end
            end

            iofrb_pkg::ST_DRAIN:
            begin
                result_valid_next            = 1'b1;
                out_seq_next                 = ne_reg;
                out_score_next               = mem_rdata[DATA_W-1:iofrb_pkg::HANDLE_W];
                out_handle_next              = mem_rdata[iofrb_pkg::HANDLE_W-1:0];
                status_next                  = iofrb_pkg::STATUS_EMIT;
                last_next                    = !drain_more;
                slot_valid_next[ne_slot_reg] = 1'b0;
                ne_next                      = ne_reg + 1'b1;
                ne_slot_next                 = nxt_slot;
                cnt_next                     = cnt_reg + 1'b1;
                state_next                   = drain_more ? iofrb_pkg::ST_DRAIN
                                                          : iofrb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = iofrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= iofrb_pkg::ST_IDLE;
            ne_reg           <= '0;
            ne_slot_reg      <= '0;
            slot_valid_reg   <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ne_reg           <= ne_next;
            ne_slot_reg      <= ne_slot_next;
            slot_valid_reg   <= slot_valid_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg    <= seq_num;
            score_reg  <= score;
            handle_reg <= payload_handle;
        end
        out_seq_reg    <= out_seq_next;
        out_score_reg  <= out_score_next;
        out_handle_reg <= out_handle_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    iofrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (park_slot),
        .wdata (mem_wdata),
        .raddr (nxt_slot),
        .rdata (mem_rdata)
    );

    assign result_valid = result_valid_reg;
    assign out_seq_num  = out_seq_reg;
    assign out_score    = out_score_reg;
    assign out_handle   = out_handle_reg;
    assign status       = status_reg;
    assign last_of_run  = last_reg;

`ifndef SYNTHESIS
    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (status_reg == iofrb_pkg::STATUS_REJECT)) |-> last_reg)
        else $error("reject transfer without last_of_run");

    a_drain_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iofrb_pkg::ST_DRAIN) |-> slot_valid_reg[ne_slot_reg])
        else $error("drain from an empty slot");

    a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_next && (status_next == iofrb_pkg::STATUS_EMIT))
        |=> (ne_reg == $past(ne_reg) + 1'b1))
        else $error("in-order transfer did not advance next expected");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_next |-> ((state_reg == iofrb_pkg::ST_CALC)
                               || (state_reg == iofrb_pkg::ST_DRAIN)))
        else $error("result formed outside check or drain");
`endif

endmodule

@@ hdl/iofrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iofrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
